[rtl/lscd_pkg.sv]
package lscd_pkg;

   // width of every configuration register and of the tick counters
   localparam int CFG_W = 8;
   localparam int CNT_W = 8;
   localparam int CSR_IDX_W = 3;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_VOID_DEBOUNCE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STAGE_TIMEOUT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRAIGHTEN_HOLD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_ZONE_MASK   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_ZONE_MASK  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_ZONE_MASK = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MIDDLE_ZONE_MASK = 3'd6;

   // register values after reset
   localparam logic [CFG_W-1:0] RST_VOID_DEBOUNCE    = 8'd3;
   localparam logic [CFG_W-1:0] RST_STAGE_TIMEOUT    = 8'd150;
   localparam logic [CFG_W-1:0] RST_STRAIGHTEN_HOLD  = 8'd5;
   localparam logic [CFG_W-1:0] RST_LEFT_ZONE_MASK   = 8'd7;
   localparam logic [CFG_W-1:0] RST_RIGHT_ZONE_MASK  = 8'd224;
   localparam logic [CFG_W-1:0] RST_CENTER_ZONE_MASK = 8'd24;
   localparam logic [CFG_W-1:0] RST_MIDDLE_ZONE_MASK = 8'd60;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   typedef enum logic [2:0] {
      STG_IDLE     = 3'd0,
      STG_ENTER    = 3'd1,
      STG_VOID     = 3'd2,
      STG_REACQ    = 3'd3,
      STG_STRAIGHT = 3'd4
   } stage_type;

   typedef enum logic [1:0] {
      EVT_NONE  = 2'd0,
      EVT_RIGHT = 2'd1,
      EVT_LEFT  = 2'd2
   } event_type;

   typedef struct packed {
      logic [CFG_W-1:0] void_debounce;
      logic [CFG_W-1:0] stage_timeout;
      logic [CFG_W-1:0] straighten_hold;
      logic [CFG_W-1:0] left_zone_mask;
      logic [CFG_W-1:0] right_zone_mask;
      logic [CFG_W-1:0] center_zone_mask;
      logic [CFG_W-1:0] middle_zone_mask;
   } cfg_type;

   typedef struct packed {
      stage_type        stage;
      logic [CNT_W-1:0] stage_count;
      logic [CNT_W-1:0] white_count;
      logic             turn_left;
   } state_type;

   localparam state_type STATE_RESET = '{
      stage:       STG_IDLE,
      stage_count: '0,
      white_count: '0,
      turn_left:   1'b0
   };

   // saturating increment of a tick counter
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      sat_inc = (v == CNT_MAX) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
   endfunction

endpackage

[rtl/lscd_csr.sv]
module lscd_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lscd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lscd_pkg::CFG_W-1:0]       csr_wdata,
   output lscd_pkg::cfg_type                cfg
);
   import lscd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // always take a write
   assign csr_ready = 1'b1;

   // decode the index; drop writes beyond the register list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_VOID_DEBOUNCE:    cfg_in.void_debounce    = csr_wdata;
            CSR_STAGE_TIMEOUT:    cfg_in.stage_timeout    = csr_wdata;
            CSR_STRAIGHTEN_HOLD:  cfg_in.straighten_hold  = csr_wdata;
            CSR_LEFT_ZONE_MASK:   cfg_in.left_zone_mask   = csr_wdata;
            CSR_RIGHT_ZONE_MASK:  cfg_in.right_zone_mask  = csr_wdata;
            CSR_CENTER_ZONE_MASK: cfg_in.center_zone_mask = csr_wdata;
            CSR_MIDDLE_ZONE_MASK: cfg_in.middle_zone_mask = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.void_debounce    <= RST_VOID_DEBOUNCE;
         cfg_ff.stage_timeout    <= RST_STAGE_TIMEOUT;
         cfg_ff.straighten_hold  <= RST_STRAIGHTEN_HOLD;
         cfg_ff.left_zone_mask   <= RST_LEFT_ZONE_MASK;
         cfg_ff.right_zone_mask  <= RST_RIGHT_ZONE_MASK;
         cfg_ff.center_zone_mask <= RST_CENTER_ZONE_MASK;
         cfg_ff.middle_zone_mask <= RST_MIDDLE_ZONE_MASK;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/lscd_step.sv]
module lscd_step #(
   parameter int CHANNELS = 8
) (
   input  logic [CHANNELS-1:0]  sensor,
   input  lscd_pkg::cfg_type    cfg,
   input  lscd_pkg::state_type  cur,
   output lscd_pkg::state_type  nxt,
   output lscd_pkg::event_type  evt
);
   import lscd_pkg::*;

   // common width for sensor and masks, which may differ in size
   localparam int ZW = (CHANNELS > CFG_W) ? CHANNELS : CFG_W;

   logic [ZW-1:0] s_w;
   logic [ZW-1:0] left_w;
   logic [ZW-1:0] right_w;
   logic [ZW-1:0] center_w;
   logic [ZW-1:0] middle_w;
   logic          white;
   logic          left_full;
   logic          right_full;
   logic          middle_hit;
   logic          straight;

   assign s_w      = ZW'(sensor);
   assign left_w   = ZW'(cfg.left_zone_mask);
   assign right_w  = ZW'(cfg.right_zone_mask);
   assign center_w = ZW'(cfg.center_zone_mask);
   assign middle_w = ZW'(cfg.middle_zone_mask);

   // zone tests on the current sample
   assign white      = (sensor == '0);
   assign left_full  = ((s_w & left_w) == left_w);
   assign right_full = ((s_w & right_w) == right_w);
   assign middle_hit = ((s_w & middle_w) != '0);
   assign straight   = ((s_w & (left_w | right_w)) == '0) && ((s_w & center_w) != '0);

   // one recognizer step: timeout check first, then the stage logic
   always_comb begin
      nxt = cur;
      evt = EVT_NONE;
      if (cur.stage_count >= cfg.stage_timeout) begin
         nxt.stage       = STG_IDLE;
         nxt.stage_count = '0;
         nxt.white_count = '0;
      end
      case (nxt.stage)
         STG_IDLE: begin
            nxt.white_count = '0;
            // left zone wins when both edges are black
            if (left_full) begin
               nxt.stage       = STG_ENTER;
               nxt.stage_count = '0;
               nxt.turn_left   = 1'b0;
            end else if (right_full) begin
               nxt.stage       = STG_ENTER;
               nxt.stage_count = '0;
               nxt.turn_left   = 1'b1;
            end
         end
         STG_ENTER: begin
            if (white) begin
               nxt.white_count = sat_inc(nxt.white_count);
               if (nxt.white_count >= cfg.void_debounce) begin
                  nxt.stage       = STG_VOID;
                  nxt.stage_count = '0;
               end
            end else begin
               nxt.white_count = '0;
               nxt.stage_count = sat_inc(nxt.stage_count);
            end
         end
         STG_VOID: begin
            if (middle_hit) begin
               nxt.stage       = STG_REACQ;
               nxt.stage_count = '0;
               nxt.white_count = '0;
            end else if (!white) begin
               // stray black outside the middle band
               nxt.stage       = STG_IDLE;
               nxt.stage_count = '0;
            end else begin
               nxt.stage_count = sat_inc(nxt.stage_count);
            end
         end
         STG_REACQ: begin
            nxt.stage_count = sat_inc(nxt.stage_count);
            if (straight && (nxt.stage_count >= cfg.straighten_hold)) begin
               nxt.stage = STG_STRAIGHT;
               evt       = nxt.turn_left ? EVT_LEFT : EVT_RIGHT;
            end
         end
         STG_STRAIGHT: begin
            nxt.stage       = STG_IDLE;
            nxt.stage_count = '0;
            nxt.white_count = '0;
         end
         default: begin
            nxt.stage = STG_IDLE;
         end
      endcase
   end

endmodule

[rtl/line_sensor_corner_detector_core.sv]
// Corner recognizer for a line-following sensor bar.
// Request channel (req_valid/req_ready/req_sensor_bits) carries one sensor
// sample per transfer, bit set meaning black. Each sample yields exactly one
// response transfer on rsp_valid/rsp_ready carrying rsp_corner_event
// (none, right or left corner confirmed) and rsp_current_stage (stage after
// the sample).
// Configuration registers are written through csr_valid/csr_index/csr_wdata;
// csr_ready is always high. Write them only while no sample is in flight.
// Path: a sample is captured in the input register, then the step logic updates
// the recognizer state and loads the response register once that is free.
// Throughput: one sample per cycle while responses are taken; the state update
// in the step logic is combinational.
// Stall: while the response waits, the input register can still take one
// sample; further requests see req_ready low until the response is taken.
// Reset: both stages empty, recognizer idle with cleared counters, and
// registers at their default values.
module line_sensor_corner_detector_core #(
   parameter int CHANNELS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [CHANNELS-1:0]              req_sensor_bits,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_corner_event,
   output logic [2:0]                       rsp_current_stage,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lscd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lscd_pkg::CFG_W-1:0]       csr_wdata
);
   import lscd_pkg::*;

   cfg_type             cfg;
   state_type           state_ff;
   state_type           state_in;
   state_type           step_nxt;
   event_type           step_evt;
   logic                in_valid_ff;
   logic                in_valid_in;
   logic [CHANNELS-1:0] in_bits_ff;
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [1:0]          out_event_ff;
   logic [2:0]          out_stage_ff;
   logic                advance;
   logic                req_xfer;

   lscd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lscd_step #(
      .CHANNELS (CHANNELS)
   ) u_step (
      .sensor (in_bits_ff),
      .cfg    (cfg),
      .cur    (state_ff),
      .nxt    (step_nxt),
      .evt    (step_evt)
   );

   // move the held sample into the response register when it is free
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   assign in_valid_in  = req_xfer || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);
   assign state_in     = advance ? step_nxt : state_ff;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload: capture on transfer, hold otherwise
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_bits_ff <= req_sensor_bits;
      end
      if (advance) begin
         out_event_ff <= step_evt;
         out_stage_ff <= step_nxt.stage;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_corner_event  = out_event_ff;
   assign rsp_current_stage = out_stage_ff;

   // a corner event comes only with the straighten stage
   a_event_stage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_corner_event != EVT_NONE) |-> (rsp_current_stage == STG_STRAIGHT))
      else $error("corner event without straighten stage");

   // the straighten stage always carries a corner event
   a_stage_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_current_stage == STG_STRAIGHT) |-> (rsp_corner_event != EVT_NONE))
      else $error("straighten stage without corner event");

   // backpressure only when both registers are occupied
   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("request stalled with free space");

   // state moves only with a sample stepping through
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (state_ff == $past(state_ff)))
      else $error("recognizer state changed without a sample");

   // both stages empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !in_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

[sim/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lscd_pkg::*;

   localparam int SENSOR_W    = 8;
   localparam int CYCLE_LIMIT = 200000;
   // the index past the last register, which the block must ignore
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd7;

   localparam logic [SENSOR_W-1:0] DIRECTED_BITS [31] = '{
      // right turn with a broken white run and a crooked reacquire sample
      8'h00, 8'h07, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00,
      8'h18, 8'h18, 8'h3C, 8'h18, 8'h18, 8'h18, 8'hFF,
      // left turn straight through to the event
      8'hE0, 8'h00, 8'h00, 8'h00, 8'h10, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08, 8'h00,
      // both edges black, then stray black outside the middle band in void
      8'hFF, 8'h00, 8'h00, 8'h00, 8'h81
   };

   typedef struct {
      event_type evt;
      stage_type stage;
   } corner_result;

   // Tracks the recognizer per accepted sample and checks the responses in order.
   class corner_scoreboard;
      cfg_type          regs;
      stage_type        stage;
      logic [CNT_W-1:0] stage_count;
      logic [CNT_W-1:0] white_count;
      bit               turn_left;
      corner_result     results_due[$];
      int               errors;
      int               samples_seen;
      int               results_seen;
      int               corners_seen;

      function new();
         regs.void_debounce    = RST_VOID_DEBOUNCE;
         regs.stage_timeout    = RST_STAGE_TIMEOUT;
         regs.straighten_hold  = RST_STRAIGHTEN_HOLD;
         regs.left_zone_mask   = RST_LEFT_ZONE_MASK;
         regs.right_zone_mask  = RST_RIGHT_ZONE_MASK;
         regs.center_zone_mask = RST_CENTER_ZONE_MASK;
         regs.middle_zone_mask = RST_MIDDLE_ZONE_MASK;
         stage       = STG_IDLE;
         stage_count = '0;
         white_count = '0;
         turn_left   = 1'b0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
         case (idx)
            CSR_VOID_DEBOUNCE:    regs.void_debounce    = d;
            CSR_STAGE_TIMEOUT:    regs.stage_timeout    = d;
            CSR_STRAIGHTEN_HOLD:  regs.straighten_hold  = d;
            CSR_LEFT_ZONE_MASK:   regs.left_zone_mask   = d;
            CSR_RIGHT_ZONE_MASK:  regs.right_zone_mask  = d;
            CSR_CENTER_ZONE_MASK: regs.center_zone_mask = d;
            CSR_MIDDLE_ZONE_MASK: regs.middle_zone_mask = d;
            default: ;
         endcase
      endfunction

      // tick counters stick at all ones
      function logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] v);
         return (v == CNT_MAX) ? v : v + 1'b1;
      endfunction

      // Advance the recognizer by one sample and queue the response it yields.
      function void note_sample(logic [SENSOR_W-1:0] s);
         corner_result     r;
         logic [CFG_W-1:0] outer;
         bit               straight;
         r.evt = EVT_NONE;
         outer = regs.left_zone_mask | regs.right_zone_mask;
         straight = ((s & outer) == '0) && ((s & regs.center_zone_mask) != '0);

         // timeout is checked before anything else in the step
         if (stage_count >= regs.stage_timeout) begin
            stage       = STG_IDLE;
            stage_count = '0;
            white_count = '0;
         end

         case (stage)
            STG_IDLE: begin
               white_count = '0;
               if ((s & regs.left_zone_mask) == regs.left_zone_mask) begin
                  stage       = STG_ENTER;
                  stage_count = '0;
                  turn_left   = 1'b0;
               end else if ((s & regs.right_zone_mask) == regs.right_zone_mask) begin
                  stage       = STG_ENTER;
                  stage_count = '0;
                  turn_left   = 1'b1;
               end
            end
            STG_ENTER: begin
               if (s == '0) begin
                  white_count = count_up(white_count);
                  if (white_count >= regs.void_debounce) begin
                     stage       = STG_VOID;
                     stage_count = '0;
                  end
               end else begin
                  white_count = '0;
                  stage_count = count_up(stage_count);
               end
            end
            STG_VOID: begin
               if ((s & regs.middle_zone_mask) != '0) begin
                  stage       = STG_REACQ;
                  stage_count = '0;
                  white_count = '0;
               end else begin
                  stage_count = count_up(stage_count);
                  if (s != '0) begin
                     stage       = STG_IDLE;
                     stage_count = '0;
                  end
               end
            end
            STG_REACQ: begin
               stage_count = count_up(stage_count);
               if (straight && stage_count >= regs.straighten_hold) begin
                  stage = STG_STRAIGHT;
                  r.evt = turn_left ? EVT_LEFT : EVT_RIGHT;
               end
            end
            STG_STRAIGHT: begin
               stage       = STG_IDLE;
               stage_count = '0;
               white_count = '0;
            end
            default: stage = STG_IDLE;
         endcase

         r.stage = stage;
         results_due.push_back(r);
         samples_seen++;
      endfunction

      // Compare one response transfer with the oldest pending prediction.
      function void check_result(logic [1:0] evt, logic [2:0] stg);
         corner_result r;
         results_seen++;
         if (evt != EVT_NONE) corners_seen++;
         if (results_due.size() == 0) begin
            errors++;
            $display("%0t: response with nothing pending: event %0d stage %0d",
                     $time, evt, stg);
            return;
         end
         r = results_due.pop_front();
         if (evt !== r.evt) begin
            errors++;
            $display("%0t: corner_event expected %0d actual %0d", $time, r.evt, evt);
         end
         if (stg !== r.stage) begin
            errors++;
            $display("%0t: current_stage expected %0d actual %0d", $time, r.stage, stg);
         end
      endfunction

      function void flush_leftovers();
         corner_result r;
         while (results_due.size() > 0) begin
            r = results_due.pop_front();
            errors++;
            $display("%0t: response never arrived: expected event %0d stage %0d",
                     $time, r.evt, r.stage);
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset           = 1'b1;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [SENSOR_W-1:0]   req_sensor_bits = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [1:0]            rsp_corner_event;
   logic [2:0]            rsp_current_stage;
   logic                  csr_valid       = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CFG_W-1:0]      csr_wdata       = '0;

   corner_scoreboard sb = new();
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_off       = 0;
   int cycle_count    = 0;
   int settings_used  = 0;

   line_sensor_corner_detector_core #(
      .CHANNELS(SENSOR_W)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sensor_bits   (req_sensor_bits),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_corner_event  (rsp_corner_event),
      .rsp_current_stage (rsp_current_stage),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Stall the response side at random, or hold it off for a requested stretch.
   initial begin
      forever @(negedge clock) begin
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
            hold_off--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Check every response transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_corner_event, rsp_current_stage);
   end

   // Bound the run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: run stopped after %0d cycles", $time, cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic set_idling(input int send_pct, input int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // Offer one sample, with an optional idle gap first, and hold until transfer.
   task automatic send_sample(input logic [SENSOR_W-1:0] bits);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_sensor_bits <= bits;
      do @(posedge clock); while (!req_ready);
      sb.note_sample(bits);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= d;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(idx, d);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_config(input logic [CFG_W-1:0] debounce, input logic [CFG_W-1:0] timeout,
                               input logic [CFG_W-1:0] hold, input logic [CFG_W-1:0] left,
                               input logic [CFG_W-1:0] right, input logic [CFG_W-1:0] center,
                               input logic [CFG_W-1:0] middle);
      write_reg(CSR_VOID_DEBOUNCE, debounce);
      write_reg(CSR_STAGE_TIMEOUT, timeout);
      write_reg(CSR_STRAIGHTEN_HOLD, hold);
      write_reg(CSR_LEFT_ZONE_MASK, left);
      write_reg(CSR_RIGHT_ZONE_MASK, right);
      write_reg(CSR_CENTER_ZONE_MASK, center);
      write_reg(CSR_MIDDLE_ZONE_MASK, middle);
      settings_used++;
   endtask

   // Drop valid, wait for every response, then let the pipeline settle.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.results_due.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // One corner maneuver with random content, sometimes broken on purpose.
   task automatic drive_corner();
      int                  lead;
      int                  wobble;
      int                  whites;
      int                  hold_len;
      logic [SENSOR_W-1:0] band;
      logic [SENSOR_W-1:0] straight_bits;
      logic [SENSOR_W-1:0] bits;
      lead = $urandom_range(0, 3);
      repeat (lead) send_sample(SENSOR_W'($urandom_range(0, 255)));

      // edge zone fully black
      if ($urandom_range(1))
         send_sample(SENSOR_W'($urandom_range(0, 255)) | sb.regs.left_zone_mask);
      else
         send_sample(SENSOR_W'($urandom_range(0, 255)) | sb.regs.right_zone_mask);

      wobble = $urandom_range(0, 2);
      repeat (wobble) send_sample(SENSOR_W'($urandom_range(1, 255)));

      // white run around the debounce length
      whites = int'(sb.regs.void_debounce);
      if ($urandom_range(99) < 15 && whites > 0)
         whites = whites - 1;
      else
         whites = whites + int'($urandom_range(0, 3));
      repeat (whites) send_sample('0);

      // black back in the middle band
      band = sb.regs.middle_zone_mask & SENSOR_W'($urandom_range(0, 255));
      if (band == '0) band = sb.regs.middle_zone_mask;
      if ($urandom_range(99) < 20) band = band | SENSOR_W'($urandom_range(0, 255));
      send_sample(band);

      // mostly straight readings until past the hold count
      straight_bits = sb.regs.center_zone_mask &
                      ~(sb.regs.left_zone_mask | sb.regs.right_zone_mask);
      hold_len = int'(sb.regs.straighten_hold > 8'd24 ? 8'd24 : sb.regs.straighten_hold) +
                 int'($urandom_range(0, 3));
      repeat (hold_len) begin
         bits = straight_bits & SENSOR_W'($urandom_range(0, 255));
         if (bits == '0) bits = straight_bits;
         if (straight_bits == '0 || $urandom_range(99) < 25)
            bits = SENSOR_W'($urandom_range(0, 255));
         send_sample(bits);
      end
      send_sample(SENSOR_W'($urandom_range(0, 255)));
   endtask

   task automatic run_random(input int count);
      int target;
      target = sb.samples_seen + count;
      while (sb.samples_seen < target) begin
         if ($urandom_range(99) < 20) begin
            case ($urandom_range(0, 3))
               0:       send_sample('0);
               1:       send_sample('1);
               default: send_sample(SENSOR_W'($urandom_range(0, 255)));
            endcase
         end else begin
            drive_corner();
         end
      end
      wait_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed samples at the default settings, no idling
      apply_config(RST_VOID_DEBOUNCE, RST_STAGE_TIMEOUT, RST_STRAIGHTEN_HOLD,
                   RST_LEFT_ZONE_MASK, RST_RIGHT_ZONE_MASK, RST_CENTER_ZONE_MASK,
                   RST_MIDDLE_ZONE_MASK);
      set_idling(0, 0);
      foreach (DIRECTED_BITS[i]) send_sample(DIRECTED_BITS[i]);
      wait_drained();

      // debounce and hold of one, timeout of 254
      apply_config(8'd1, 8'd254, 8'd1, 8'h03, 8'hC0, 8'h18, 8'h3C);
      set_idling(47, 0);
      run_random(70);

      // longest debounce: one full white run to saturation
      apply_config(8'd255, 8'd254, 8'd3, 8'h07, 8'hE0, 8'h18, 8'h7E);
      set_idling(0, 0);
      drive_corner();
      run_random(10);

      // hold the response side off while samples keep coming
      apply_config(8'd2, 8'd60, 8'd4, 8'h0F, 8'hF0, 8'h18, 8'h3C);
      set_idling(0, 47);
      hold_off = 80;
      run_random(70);

      // empty left and center masks, full right and middle, tight timeout
      apply_config(8'd1, 8'd1, 8'd254, 8'h00, 8'hFF, 8'h00, 8'hFF);
      set_idling(7, 7);
      run_random(30);

      // the mirror of the above
      apply_config(8'd2, 8'd20, 8'd254, 8'hFF, 8'h00, 8'hFF, 8'h00);
      run_random(30);

      // zero debounce and timeout, then zero debounce alone
      apply_config(8'd0, 8'd0, 8'd1, 8'h07, 8'hE0, 8'h18, 8'h3C);
      set_idling(0, 0);
      run_random(15);
      apply_config(8'd0, 8'd200, 8'd2, 8'h01, 8'h80, 8'h18, 8'h7E);
      write_reg(CSR_SPARE, CFG_W'($urandom_range(0, 255)));
      set_idling(47, 0);
      run_random(50);

      // random settings across the idling mixes
      for (int p = 0; p < 3; p++) begin
         apply_config(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(8, 254)),
                      CFG_W'($urandom_range(1, 12)),
                      CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)),
                      CFG_W'($urandom_range(0, 255)), CFG_W'($urandom_range(0, 255)));
         case (p)
            0:       set_idling(0, 47);
            1:       set_idling(7, 7);
            default: set_idling(0, 0);
         endcase
         run_random(35);
      end

      sb.flush_leftovers();
      $display("Sent %0d sensor samples under %0d register settings;", sb.samples_seen,
               settings_used);
      $display("checked %0d responses, %0d of them corner events.", sb.results_seen,
               sb.corners_seen);
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
